### rtl/gregorian_date_check_and_step_assert.svh
// assertion macros used by the top-level rtl file
`ifndef GREGORIAN_DATE_CHECK_AND_STEP_ASSERT_SVH
`define GREGORIAN_DATE_CHECK_AND_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define GDCS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: condition does not hold");

// antecedent implies consequent in the next cycle
`define GDCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: expected follow-up did not occur");

`else

`define GDCS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define GDCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/gdcs_pkg.sv
// types, constants and the month length helper function for the gregorian date checker
package gdcs_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;

    // year / 25 as (year * DIV25_MUL) >> DIV25_SHIFT, exact for 16-bit years
    localparam int DIV25_MUL_W = 17;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 17'd83887;
    localparam int DIV25_SHIFT = 21;
    localparam int PROD_W      = YEAR_W + DIV25_MUL_W;
    localparam int QUOT_W      = PROD_W - DIV25_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    typedef struct packed {
        logic [DAY_W-1:0]   day_in;
        logic [MONTH_W-1:0] month_in;
        logic [YEAR_W-1:0]  year_in;
    } t_date_in;

    typedef struct packed {
        logic               date_ok;
        logic [DAY_W-1:0]   prev_day;
        logic [MONTH_W-1:0] prev_month;
        logic [YEAR_W-1:0]  prev_year;
        logic [DAY_W-1:0]   next_day;
        logic [MONTH_W-1:0] next_month;
        logic [YEAR_W-1:0]  next_year;
    } t_date_out;

    // checked date with the month lengths needed for stepping
    typedef struct packed {
        t_date_in         date;
        logic             ok;
        logic [DAY_W-1:0] cur_len;
        logic [DAY_W-1:0] prv_len;
    } t_date_chk;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            MONTH_FEB:                               len = leap ? LEN_FEB_LEAP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default:                                 len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

### rtl/gregorian_date_check_and_step.sv
// top level of the gregorian date checker with previous and next day
// usage:
//   input channel: i_valid / o_stall carry a request i_req with day, month
//     and year; a request is taken at a clock edge with i_valid high and
//     o_stall low
//   output channel: o_valid / i_stall carry o_rsp with the validity flag and
//     the previous and next dates, all zero for an invalid date
//   pipeline: one request per cycle sustained while i_stall stays low,
//     through the three register stages (divide by 25, leap and month
//     length check, day step)
//   stall: each stage holds when the stage after it is full and stalled,
//     so empty stages keep filling; o_stall rises only with all three full
//   reset: synchronous, active low, empties the pipeline; no clearing pass
module gregorian_date_check_and_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gdcs_pkg::t_date_in  i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output gdcs_pkg::t_date_out o_rsp
);
    import gdcs_pkg::*;

    `include "gregorian_date_check_and_step_assert.svh"

    // stage valids and load enables
    logic              s1_valid;
    logic              s2_valid;
    logic              s3_valid;
    logic              s1_load;
    logic              s2_load;
    logic              s3_load;

    // stage payloads
    t_date_in          s1_date;
    logic [QUOT_W-1:0] s1_quot;
    t_date_chk         s2_chk;

    // a stage loads when it is empty or its contents move on
    assign s3_load = !s3_valid || !i_stall;
    assign s2_load = !s2_valid || s3_load;
    assign s1_load = !s1_valid || s2_load;
    assign o_stall = !s1_load;

    // divide year by 25 by reciprocal multiply
    gdcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_load),
        .i_valid (i_valid),
        .i_date  (i_req),
        .o_valid (s1_valid),
        .o_date  (s1_date),
        .o_quot  (s1_quot)
    );

    // leap year, month lengths, validity
    gdcs_chk u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s2_load),
        .i_valid (s1_valid),
        .i_date  (s1_date),
        .i_quot  (s1_quot),
        .o_valid (s2_valid),
        .o_chk   (s2_chk)
    );

    // previous and next day, output register
    gdcs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s3_load),
        .i_valid (s2_valid),
        .i_chk   (s2_chk),
        .o_valid (s3_valid),
        .o_rsp   (o_rsp)
    );

    assign o_valid = s3_valid;

    // back-pressure only with a full pipeline and a stalled receiver
    `GDCS_ASSERT_ALWAYS(a_stall_full, i_clk, i_rst_n, !o_stall || (s1_valid && s2_valid && s3_valid && i_stall))
    // a taken request sits in the first stage next cycle
    `GDCS_ASSERT_NEXT(a_req_lands, i_clk, i_rst_n, i_valid && !o_stall, s1_valid)
    // a valid date always has a nonzero next and previous day and month
    `GDCS_ASSERT_ALWAYS(a_ok_dates, i_clk, i_rst_n, !(o_valid && o_rsp.date_ok) || (o_rsp.next_day != '0 && o_rsp.prev_day != '0 && o_rsp.next_month != '0 && o_rsp.prev_month != '0))
endmodule

### rtl/gdcs_div.sv
// first stage: register the request and its year divided by 25
module gdcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_valid,
    input  gdcs_pkg::t_date_in i_date,
    output logic              o_valid,
    output gdcs_pkg::t_date_in o_date,
    output logic [gdcs_pkg::QUOT_W-1:0] o_quot
);
    import gdcs_pkg::*;

    logic              r_valid;
    t_date_in          r_date;
    logic [QUOT_W-1:0] r_quot;
    logic [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_date.year_in) * PROD_W'(DIV25_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_date <= i_date;
            r_quot <= n_prod[PROD_W-1:DIV25_SHIFT];
        end
    end

    assign o_valid = r_valid;
    assign o_date  = r_date;
    assign o_quot  = r_quot;
endmodule

### rtl/gdcs_chk.sv
// second stage: leap year, month lengths and validity
module gdcs_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_valid,
    input  gdcs_pkg::t_date_in i_date,
    input  logic [gdcs_pkg::QUOT_W-1:0] i_quot,
    output logic               o_valid,
    output gdcs_pkg::t_date_chk o_chk
);
    import gdcs_pkg::*;

    logic              r_valid;
    t_date_chk         r_chk;
    t_date_chk         n_chk;
    logic [YEAR_W-1:0] quot25;
    logic              div25;
    logic              leap;
    logic              month_ok;

    // q * 25 as shifts and adds
    assign quot25 = (YEAR_W'(i_quot) << 4) + (YEAR_W'(i_quot) << 3) + YEAR_W'(i_quot);
    assign div25  = (quot25 == i_date.year_in);
    // by 4 and not by 100, or by 400 (100 = 4*25, 400 = 16*25)
    assign leap   = ((i_date.year_in[1:0] == 2'd0) && !div25)
                 || ((i_date.year_in[3:0] == 4'd0) && div25);
    assign month_ok = (i_date.month_in >= MONTH_JAN) && (i_date.month_in <= MONTH_DEC);

    always_comb begin
        n_chk.date    = i_date;
        n_chk.cur_len = month_len(i_date.month_in, leap);
        n_chk.prv_len = month_len(i_date.month_in - MONTH_JAN, leap);
        n_chk.ok      = month_ok && (i_date.day_in >= DAY_FIRST)
                     && (i_date.day_in <= n_chk.cur_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_chk <= n_chk;
        end
    end

    assign o_valid = r_valid;
    assign o_chk   = r_chk;
endmodule

### rtl/gdcs_step.sv
// third stage: previous and next date into the output register
module gdcs_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_valid,
    input  gdcs_pkg::t_date_chk i_chk,
    output logic                o_valid,
    output gdcs_pkg::t_date_out o_rsp
);
    import gdcs_pkg::*;

    logic      r_valid;
    t_date_out r_rsp;
    t_date_out n_rsp;

    always_comb begin
        n_rsp = '0;
        if (i_chk.ok) begin
            n_rsp.date_ok = 1'b1;
            if (i_chk.date.day_in > DAY_FIRST) begin
                n_rsp.prev_day   = i_chk.date.day_in - DAY_FIRST;
                n_rsp.prev_month = i_chk.date.month_in;
                n_rsp.prev_year  = i_chk.date.year_in;
            end else if (i_chk.date.month_in == MONTH_JAN) begin
                n_rsp.prev_day   = LEN_LONG;
                n_rsp.prev_month = MONTH_DEC;
                n_rsp.prev_year  = i_chk.date.year_in - YEAR_W'(1);
            end else begin
                n_rsp.prev_day   = i_chk.prv_len;
                n_rsp.prev_month = i_chk.date.month_in - MONTH_JAN;
                n_rsp.prev_year  = i_chk.date.year_in;
            end
            if (i_chk.date.day_in < i_chk.cur_len) begin
                n_rsp.next_day   = i_chk.date.day_in + DAY_FIRST;
                n_rsp.next_month = i_chk.date.month_in;
                n_rsp.next_year  = i_chk.date.year_in;
            end else if (i_chk.date.month_in == MONTH_DEC) begin
                n_rsp.next_day   = DAY_FIRST;
                n_rsp.next_month = MONTH_JAN;
                n_rsp.next_year  = i_chk.date.year_in + YEAR_W'(1);
            end else begin
                n_rsp.next_day   = DAY_FIRST;
                n_rsp.next_month = i_chk.date.month_in + MONTH_JAN;
                n_rsp.next_year  = i_chk.date.year_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule
